/* rtl/core/udiv64_pkg.sv */
// Shared types and constants for the 64-bit unsigned divider.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package udiv64_pkg;

  // Operand and result width.
  localparam int unsigned DATA_W = 64;
  // Width of the step counter: one count per quotient bit.
  localparam int unsigned CNT_W = $clog2(DATA_W);
  // Counter value at the first step; counts down to zero.
  localparam logic [CNT_W-1:0] STEP_FIRST = CNT_W'(DATA_W - 1);
  localparam logic [CNT_W-1:0] STEP_LAST = '0;

  // Input word: one division request.
  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } udiv64_req_t;

  // Output word: one division result.
  typedef struct packed {
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem_out;
    logic              div_by_zero;
  } udiv64_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } udiv64_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_zero;
  } udiv64_stat_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } udiv64_state_t;

endpackage

/* rtl/core/udiv64_dpath.sv */
// Datapath of the 64-bit unsigned divider: partial remainder, shifting
// dividend/quotient register and one 65-bit subtract. Depends on udiv64_pkg.
`timescale 1ns / 1ps

module udiv64_dpath import udiv64_pkg::*; (
  input  logic         clk,
  input  udiv64_cmd_t  cmd,
  input  udiv64_req_t  operands,
  output udiv64_stat_t stat,
  output udiv64_rsp_t  result
);

  // Dividend bits shift out at the top while quotient bits shift in at the bottom.
  logic [DATA_W-1:0] quo_div;
  logic [DATA_W-1:0] part;
  logic [DATA_W-1:0] divisor;
  logic              div_zero;

  logic [DATA_W-1:0] quo_div_next;
  logic [DATA_W-1:0] part_next;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  // The bit shifted out of the partial remainder is kept as the top trial bit.
  always_comb begin
    trial        = {part, quo_div[DATA_W-1]};
    diff         = trial - {1'b0, divisor};
    fits         = trial >= {1'b0, divisor};
    part_next    = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    quo_div_next = {quo_div[DATA_W-2:0], fits};
  end

  // Operand load and step registers; payload only, so no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_div  <= operands.dividend;
      divisor  <= operands.divisor;
      part     <= '0;
      div_zero <= (operands.divisor == '0);
    end else if (cmd.step) begin
      quo_div <= quo_div_next;
      part    <= part_next;
    end
  end

  // A zero divisor reports zero quotient and remainder.
  always_comb begin
    stat.div_zero      = div_zero;
    result.quot        = div_zero ? '0 : quo_div;
    result.rem_out     = div_zero ? '0 : part;
    result.div_by_zero = div_zero;
  end

endmodule

/* rtl/core/udiv64_ctrl.sv */
// Controller of the 64-bit unsigned divider: state machine and step counter.
// Drives datapath commands and the start/busy/done handshake. Depends on udiv64_pkg.
`timescale 1ns / 1ps

module udiv64_ctrl import udiv64_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  udiv64_stat_t stat,
  output logic         busy,
  output logic         done,
  output udiv64_cmd_t  cmd
);

  udiv64_state_t    state;
  udiv64_state_t    state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_DONE: begin
        state_next = start ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        if (stat.div_zero || cnt == STEP_LAST) begin
          state_next = ST_DONE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output and command logic.
  always_comb begin
    busy     = 1'b0;
    done     = 1'b0;
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    cnt_next = cnt;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
        if (start) begin
          cnt_next = STEP_FIRST;
        end
      end
      ST_RUN: begin
        busy     = 1'b1;
        cmd.step = !stat.div_zero;
        cnt_next = cnt - 1'b1;
      end
      ST_DONE: begin
        done     = 1'b1;
        cmd.load = start;
        if (start) begin
          cnt_next = STEP_FIRST;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

/* rtl/core/unsigned_divider_64.sv */
// Top level of the 64-bit unsigned divider.
// Instantiates udiv64_ctrl and udiv64_dpath; depends on udiv64_pkg.
`timescale 1ns / 1ps

// A word is accepted at a clock edge where start is high and busy is low.
// The divider produces one quotient bit per cycle through a single 65-bit
// subtractor; after the last quotient bit the state machine moves from run
// to done, and the result is on the ports with done high for exactly one
// cycle. The receiver cannot stall: the result is valid only while done is
// high. busy is low during that done cycle, so the next word can be accepted
// there; no word is taken while the previous one is still running. A zero
// divisor skips the quotient steps and goes from run straight to done with
// quotient and remainder zero and div_by_zero set.
module unsigned_divider_64 import udiv64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  udiv64_req_t operands,
  output logic        busy,
  output logic        done,
  output udiv64_rsp_t result
);

  udiv64_cmd_t  cmd;
  udiv64_stat_t stat;

  // Sequencing of load, steps and completion.
  udiv64_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Shift-and-subtract arithmetic.
  udiv64_dpath u_dpath (
    .clk      (clk),
    .cmd      (cmd),
    .operands (operands),
    .stat     (stat),
    .result   (result)
  );

endmodule

/* tb/unsigned_divider_64_tb.sv */
// Self-checking testbench for the 64-bit unsigned divider unsigned_divider_64.
// Checks quotient, remainder and the zero-divisor flag of every word against a
// restoring-division predictor; depends on udiv64_pkg and the divider RTL.
`timescale 1ns / 1ps

module unsigned_divider_64_tb;
  import udiv64_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 1480;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 80;

  // One division request waiting to be sent, with the pause that follows it.
  typedef struct {
    udiv64_req_t operands;
    int unsigned gap;
    bit          drain;
  } div_job_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  udiv64_req_t operands = '0;
  logic        busy;
  logic        done;
  udiv64_rsp_t result;

  div_job_t    request_words[$];
  udiv64_rsp_t due_results[$];
  udiv64_rsp_t want;
  div_job_t    job;
  logic        taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;

  unsigned_divider_64 DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always #5 clk = ~clk;

  // Restoring division: one quotient bit per step, partial remainder kept at
  // 65 bits so a divisor with its top bit set still divides exactly.
  function automatic udiv64_rsp_t restoring_divide(input udiv64_req_t w);
    udiv64_rsp_t     r;
    logic [DATA_W:0] part;
    r = '0;
    part = '0;
    if (w.divisor == '0) begin
      r.div_by_zero = 1'b1;
      return r;
    end
    for (int b = DATA_W - 1; b >= 0; b--) begin
      part = {part[DATA_W-1:0], w.dividend[b]};
      if (part >= {1'b0, w.divisor}) begin
        part = part - {1'b0, w.divisor};
        r.quot[b] = 1'b1;
      end
    end
    r.rem_out = part[DATA_W-1:0];
    return r;
  endfunction

  // Random value confined to its low w bits, w from 1 to 64.
  function automatic logic [DATA_W-1:0] rand_bits(input int unsigned w);
    logic [DATA_W-1:0] v;
    v = {$urandom, $urandom};
    return v >> (DATA_W - w);
  endfunction

  // Pause after a word: mostly none or short, now and then long enough to
  // land anywhere in a whole division.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(1, 4);
    else if (roll < 95) return $urandom_range(5, 30);
    return $urandom_range(31, 150);
  endfunction

  task automatic queue_word(input logic [DATA_W-1:0] n, input logic [DATA_W-1:0] d,
                            input int unsigned gap, input bit drain);
    div_job_t j;
    j.operands.dividend = n;
    j.operands.divisor = d;
    j.gap = gap;
    j.drain = drain;
    request_words.push_back(j);
  endtask

  // Driver: a word stays on the port until it is taken, then the next one
  // follows after its pause. A drain word waits for all results first.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (request_words.size() != 0 &&
                   (!request_words[0].drain || due_results.size() == 0)) begin
        job = request_words.pop_front();
        operands <= job.operands;
        gap_left = job.gap;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result word against the oldest prediction, then log
  // the word accepted at this edge.
  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          $error("result word with no request outstanding: %h", result);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (result.quot !== want.quot) begin
            $error("quot: expected %h, actual %h", want.quot, result.quot);
            errors++;
          end
          if (result.rem_out !== want.rem_out) begin
            $error("rem_out: expected %h, actual %h", want.rem_out, result.rem_out);
            errors++;
          end
          if (result.div_by_zero !== want.div_by_zero) begin
            $error("div_by_zero: expected %b, actual %b", want.div_by_zero,
                   result.div_by_zero);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        due_results.push_back(restoring_divide(operands));
      end
      taken <= start && !busy;
    end
  end

  // Watchdog: ends the run when no word moves in either direction for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[unsigned_divider_64] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed corner cases, then random words of mixed shapes.
  initial begin : stimulus
    logic [DATA_W-1:0] n;
    logic [DATA_W-1:0] d;
    int unsigned       kind;
    int unsigned       burst;

    // Zero divisor, including the largest dividend.
    queue_word('0, '0, 0, 1'b0);
    queue_word('1, '0, 0, 1'b0);
    queue_word(64'h0123_4567_89ab_cdef, '0, 3, 1'b0);
    // Extremes of both fields.
    queue_word('0, 64'd1, 0, 1'b0);
    queue_word('1, 64'd1, 0, 1'b0);
    queue_word('1, '1, 0, 1'b0);
    queue_word('0, '1, 1, 1'b0);
    queue_word(64'd1, '1, 0, 1'b0);
    queue_word('1, 64'd2, 0, 1'b0);
    // Divisor larger than the dividend: quotient zero, remainder the dividend.
    queue_word(64'd5, 64'd7, 0, 1'b0);
    queue_word(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 0, 1'b0);
    // Divisor with its top bit set, where the partial remainder carries out.
    queue_word('1, 64'h8000_0000_0000_0000, 0, 1'b0);
    queue_word('1, 64'h8000_0000_0000_0001, 0, 1'b0);
    queue_word(64'hfffe_0000_0000_0000, 64'hffff_0000_0000_0000, 0, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 2, 1'b0);
    // Ordinary values.
    queue_word(64'd100, 64'd7, 0, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 64'd3, 0, 1'b0);
    queue_word('1, 64'hffff_ffff, 0, 1'b0);
    queue_word(64'hdead_beef_cafe_f00d, 64'h1_0000_0000, 0, 1'b0);
    queue_word(64'd42, 64'd42, 0, 1'b0);

    // Random words; the first waits until the directed results are in.
    burst = 0;
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      kind = $urandom_range(0, 9);
      n = {$urandom, $urandom};
      d = {$urandom, $urandom};
      case (kind)
        0: begin
          d = '0;
        end
        1, 2: begin
          d = rand_bits($urandom_range(1, 16));
        end
        3, 4: begin
          n = rand_bits($urandom_range(1, DATA_W));
          d = rand_bits($urandom_range(1, DATA_W));
        end
        5: begin
          d = n + DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
        end
        6: begin
          d[DATA_W-1] = 1'b1;
          n[DATA_W-1] = 1'b1;
        end
        default: begin
        end
      endcase
      // Stretches of back-to-back words between stretches with pauses.
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
      if (burst > 0) begin
        burst--;
        queue_word(n, d, 0, i == 0);
      end else begin
        queue_word(n, d, pick_gap(), i == 0 || $urandom_range(0, 99) == 0);
      end
    end

    // Synchronous reset, released on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_words.size() != 0 || start || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[unsigned_divider_64] OK");
    end else begin
      $display("[unsigned_divider_64] ERROR");
    end
    $finish;
  end

endmodule
